// ===== rtl/motor_feedback_frame_unwrap_unit_assert.svh =====
// Assertion macros shared by the motor feedback frame unwrap unit
`ifndef MOTOR_FEEDBACK_FRAME_UNWRAP_UNIT_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_UNWRAP_UNIT_ASSERT_SVH

// same-cycle implication
`define MFFU_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mffu assertion failed");

// next-cycle implication
`define MFFU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mffu assertion failed");

`endif

// ===== rtl/mffu_pkg.sv =====
// Package: constants, types and calibration tables of the frame unwrap unit
`default_nettype none

package mffu_pkg;

    localparam int BUS_COUNT_DEF      = 4;
    localparam int MOTORS_PER_BUS_DEF = 4;
    localparam int MOTOR_W            = 2;

    localparam logic [10:0] ID_MOTOR0   = 11'h141;
    localparam logic [23:0] DPP_RESET   = 24'd10240;
    localparam logic [26:0] D2R_Q32     = 27'd74961321;
    localparam logic [25:0] DIV9_RECIP  = 26'd59652324;
    localparam int          DIV9_SHIFT  = 29;
    localparam logic [42:0] SPEED_RND   = 43'd294912;
    localparam logic [53:0] ANGLE_RND   = 54'd2147483648;
    localparam logic signed [32:0] STEP_LIMIT  = 33'sd1310720;
    localparam logic signed [33:0] CLEAR_LIMIT = 34'sd23592960;
    localparam logic [MOTOR_W-1:0] MOTOR_UNCAL = 2'd3;

    typedef enum logic [1:0] {
        ST_FULL    = 2'd0,
        ST_TRACK   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic unwrap;
        logic scale;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic ignored;
    } t_dp_stat;

    function automatic logic motor_neg(input logic [1:0] bus, input logic [MOTOR_W-1:0] m);
        logic neg;
        unique case ({bus, m})
            4'b01_01, 4'b01_10: neg = 1'b1;
            4'b10_00, 4'b10_10: neg = 1'b1;
            4'b11_00, 4'b11_01, 4'b11_10: neg = 1'b1;
            default: neg = 1'b0;
        endcase
        return neg;
    endfunction

    function automatic logic signed [24:0] motor_offset(input logic [1:0] bus,
                                                        input logic [MOTOR_W-1:0] m);
        logic signed [24:0] ofs;
        unique case ({bus, m})
            4'b00_01: ofs = 25'sd4704174;
            4'b01_01: ofs = -25'sd4744806;
            4'b10_01: ofs = 25'sd4739564;
            4'b11_01: ofs = -25'sd4705485;
            4'b01_10, 4'b10_10, 4'b11_10: ofs = 25'sd10524426;
            default: ofs = 25'sd0;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mffu_dp.sv =====
// Datapath: angle conversion, wrap tracking, scaling and result registers
`default_nettype none

module mffu_dp import mffu_pkg::*; #(
    parameter int BUS_COUNT      = BUS_COUNT_DEF,
    parameter int MOTORS_PER_BUS = MOTORS_PER_BUS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic [1:0]         i_bus,
    input  wire logic [10:0]        i_frame_id,
    input  wire logic [7:0]         i_temperature_byte,
    input  wire logic signed [15:0] i_torque_raw,
    input  wire logic signed [15:0] i_speed_raw,
    input  wire logic [15:0]        i_encoder_pulse,
    output logic [1:0]              o_status,
    output logic [3:0]              o_motor_number,
    output logic [7:0]              o_temperature,
    output logic signed [15:0]      o_torque_out,
    output logic signed [22:0]      o_speed_out,
    output logic signed [20:0]      o_angle_out
);

    localparam int SLOTS  = BUS_COUNT * MOTORS_PER_BUS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [2:0]  BUS_LIM = 3'(BUS_COUNT);
    localparam logic [10:0] MPB_LIM = 11'(MOTORS_PER_BUS);
    localparam logic [4:0]  MPB_MUL = 5'(MOTORS_PER_BUS);

    logic [23:0]              r_dpp;
    logic                     r_pend [SLOTS];
    logic signed [7:0]        r_wc   [SLOTS];
    logic [31:0]              r_prev [SLOTS];

    logic                     r_hit;
    logic [1:0]               r_bus;
    logic [MOTOR_W-1:0]       r_m;
    logic [SLOT_W-1:0]        r_slot;
    logic [7:0]               r_temp;
    logic signed [15:0]       r_torque;
    logic signed [15:0]       r_speed;
    logic [15:0]              r_pulse;
    logic [31:0]              r_deg;
    logic [42:0]              r_sprod;
    logic                     r_sneg;
    logic signed [7:0]        r_wcn;
    logic [25:0]              r_q;
    logic [26:0]              r_amag;
    logic                     r_aneg;
    logic [53:0]              r_aprod;
    logic [51:0]              r_sq;

    logic [1:0]               r_status;
    logic [3:0]               r_motor;
    logic [7:0]               r_temp_out;
    logic [15:0]              r_torque_out;
    logic [22:0]              r_speed_out;
    logic [20:0]              r_angle_out;

    logic [10:0]              n_m_full;
    logic                     n_hit;
    logic [4:0]               n_slot_full;
    logic                     neg;
    logic signed [24:0]       ofs;
    logic [39:0]              deg_prod;
    logic [15:0]              smag;
    logic [31:0]              prev;
    logic signed [32:0]       diff;
    logic signed [7:0]        wc_cur;
    logic signed [7:0]        n_wcn;
    logic [42:0]              q_sum;
    logic signed [13:0]       wc40;
    logic signed [33:0]       unwrapped;
    logic                     clear;
    logic signed [34:0]       a_val;
    logic [34:0]              amag;
    logic [53:0]              ar_sum;
    logic [21:0]              ar;
    logic [21:0]              sr;
    logic [20:0]              n_angle;
    logic [22:0]              n_speed;
    logic [15:0]              n_torque;

    always_comb begin
        n_m_full    = i_frame_id - ID_MOTOR0;
        n_hit       = ({1'b0, i_bus} < BUS_LIM) && (n_m_full < MPB_LIM);
        n_slot_full = 5'({3'b000, i_bus} * MPB_MUL) + {3'b000, n_m_full[MOTOR_W-1:0]};

        neg = motor_neg(r_bus, r_m);
        ofs = motor_offset(r_bus, r_m);

        deg_prod = 40'(r_pulse) * 40'(r_dpp);
        smag     = r_speed[15] ? 16'(16'sd0 - r_speed) : 16'(r_speed);

        prev   = r_pend[r_slot] ? r_deg : r_prev[r_slot];
        diff   = $signed({1'b0, r_deg}) - $signed({1'b0, prev});
        wc_cur = r_wc[r_slot];
        if (diff < -STEP_LIMIT) begin
            n_wcn = wc_cur + 8'sd1;
        end else if (diff > STEP_LIMIT) begin
            n_wcn = wc_cur - 8'sd1;
        end else begin
            n_wcn = wc_cur;
        end
        q_sum = r_sprod + SPEED_RND;

        wc40      = (14'(r_wcn) <<< 5) + (14'(r_wcn) <<< 3);
        unwrapped = 34'($signed({wc40, 16'h0000})) + $signed({2'b00, r_deg});
        clear     = (unwrapped > CLEAR_LIMIT) || (unwrapped < -CLEAR_LIMIT);
        a_val     = 35'(unwrapped) + 35'(ofs);
        amag      = a_val[34] ? 35'(35'sd0 - a_val) : 35'(a_val);

        ar_sum = r_aprod + ANGLE_RND;
        ar     = ar_sum[53:32];
        sr     = r_sq[DIV9_SHIFT+21:DIV9_SHIFT];

        if (r_aneg) begin
            n_angle = (ar > 22'd1048576) ? 21'h100000 : 21'(22'd0 - ar);
        end else begin
            n_angle = (ar > 22'd1048575) ? 21'h0FFFFF : ar[20:0];
        end
        n_speed = r_sneg ? 23'(23'd0 - {1'b0, sr}) : {1'b0, sr};
        if (neg) begin
            n_torque = (r_torque == -16'sd32768) ? 16'h7FFF : 16'(16'sd0 - r_torque);
        end else begin
            n_torque = 16'(r_torque);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpp <= DPP_RESET;
            for (int k = 0; k < SLOTS; k++) begin
                r_pend[k] <= 1'b1;
                r_wc[k]   <= 8'sd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_dpp <= i_cfg_data;
            end
            if (i_cmd.unwrap && r_hit) begin
                r_pend[r_slot] <= 1'b0;
                r_wc[r_slot]   <= clear ? 8'sd0 : r_wcn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit    <= n_hit;
            r_bus    <= i_bus;
            r_m      <= n_m_full[MOTOR_W-1:0];
            r_slot   <= n_slot_full[SLOT_W-1:0];
            r_temp   <= i_temperature_byte;
            r_torque <= i_torque_raw;
            r_speed  <= i_speed_raw;
            r_pulse  <= i_encoder_pulse;
        end
        if (i_cmd.mul) begin
            r_deg   <= deg_prod[39:8];
            r_sprod <= 43'(smag) * 43'(D2R_Q32);
            r_sneg  <= r_speed[15] ^ neg;
        end
        if (i_cmd.step) begin
            r_wcn <= n_wcn;
            r_q   <= q_sum[41:16];
        end
        if (i_cmd.unwrap) begin
            if (r_hit) begin
                r_prev[r_slot] <= r_deg;
            end
            r_amag <= (|amag[34:27]) ? {27{1'b1}} : amag[26:0];
            r_aneg <= a_val[34] ^ neg;
        end
        if (i_cmd.scale) begin
            r_aprod <= 54'(r_amag) * 54'(D2R_Q32);
            r_sq    <= 52'(r_q) * 52'(DIV9_RECIP);
        end
        if (i_cmd.fin) begin
            r_status     <= ST_FULL;
            r_motor      <= 4'(r_m);
            r_temp_out   <= r_temp;
            r_torque_out <= n_torque;
            r_speed_out  <= n_speed;
            r_angle_out  <= n_angle;
            if (!r_hit) begin
                r_status   <= ST_IGNORED;
                r_motor    <= 4'd0;
                r_temp_out <= 8'd0;
            end
            if (!r_hit || r_m == MOTOR_UNCAL) begin
                r_torque_out <= 16'd0;
                r_speed_out  <= 23'd0;
                r_angle_out  <= 21'd0;
            end
            if (r_hit && r_m == MOTOR_UNCAL) begin
                r_status <= ST_TRACK;
            end
        end
    end

    assign o_stat.ignored = !r_hit;
    assign o_status       = r_status;
    assign o_motor_number = r_motor;
    assign o_temperature  = r_temp_out;
    assign o_torque_out   = $signed(r_torque_out);
    assign o_speed_out    = $signed(r_speed_out);
    assign o_angle_out    = $signed(r_angle_out);

endmodule

`default_nettype wire

// ===== rtl/mffu_ctrl.sv =====
// Controller: sequences one frame through the datapath and owns the handshakes
`default_nettype none
`include "motor_feedback_frame_unwrap_unit_assert.svh"

module mffu_ctrl import mffu_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  wire logic     i_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_STEP,
        S_UNWRAP,
        S_SCALE,
        S_FIN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = i_stat.ignored ? S_FIN : S_STEP;
            end
            S_STEP: begin
                cmd.step = 1'b1;
                n_state  = S_UNWRAP;
            end
            S_UNWRAP: begin
                cmd.unwrap = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    cmd.fin     = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `MFFU_ASSERT_IMPLY(a_fin_slot_free, i_clk, i_rst_n, cmd.fin, !r_out_valid || i_ready)
    `MFFU_ASSERT_NEXT(a_load_starts, i_clk, i_rst_n, cmd.load, r_state == S_MUL)
    `MFFU_ASSERT_NEXT(a_fin_shows, i_clk, i_rst_n, cmd.fin, r_out_valid)
    `MFFU_ASSERT_IMPLY(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(cmd))

endmodule

`default_nettype wire

// ===== rtl/motor_feedback_frame_unwrap_unit.sv =====
// Top level of the motor feedback frame unwrap unit
// One word at a time: a frame is taken only while the unit is idle.
// Each word goes through the sequencer steps load, multiply, step, unwrap, scale and finish,
// and an ignored identifier skips from multiply to finish. No new word is taken before the
// last one is through; a result left waiting stalls the sequencer in its last step.
// Synchronous active-low reset clears per-motor tracking and loads 10240 into the config.
`default_nettype none

module motor_feedback_frame_unwrap_unit import mffu_pkg::*; #(
    parameter int BUS_COUNT      = BUS_COUNT_DEF,
    parameter int MOTORS_PER_BUS = MOTORS_PER_BUS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_bus,
    input  wire logic [10:0]        i_frame_id,
    input  wire logic [7:0]         i_temperature_byte,
    input  wire logic signed [15:0] i_torque_raw,
    input  wire logic signed [15:0] i_speed_raw,
    input  wire logic [15:0]        i_encoder_pulse,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [3:0]              o_motor_number,
    output logic [7:0]              o_temperature,
    output logic signed [15:0]      o_torque_out,
    output logic signed [22:0]      o_speed_out,
    output logic signed [20:0]      o_angle_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mffu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mffu_dp #(
        .BUS_COUNT      (BUS_COUNT),
        .MOTORS_PER_BUS (MOTORS_PER_BUS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_bus              (i_bus),
        .i_frame_id         (i_frame_id),
        .i_temperature_byte (i_temperature_byte),
        .i_torque_raw       (i_torque_raw),
        .i_speed_raw        (i_speed_raw),
        .i_encoder_pulse    (i_encoder_pulse),
        .o_status           (o_status),
        .o_motor_number     (o_motor_number),
        .o_temperature      (o_temperature),
        .o_torque_out       (o_torque_out),
        .o_speed_out        (o_speed_out),
        .o_angle_out        (o_angle_out)
    );

endmodule

`default_nettype wire
